// ----- design/websocket_frame_deframer_defines.svh -----
// Assertion macros shared by the deframer checker.
// Depends on nothing; include by bare file name.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser, the output buffer and the top level.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_MSG     = 3'd1,
        EV_PING    = 3'd2,
        EV_DISCARD = 3'd3,
        EV_CLOSE   = 3'd4,
        EV_ERROR   = 3'd5
    } event_t;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [1:0] MT_NONE = 2'd0;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

    typedef struct packed {
        logic [1:0] message_type;
        logic       message_end;
        logic       frame_end;
        logic [7:0] out_byte;
        event_t     event_res;
    } res_t;

endpackage

// ----- design/wsd_parser.sv -----
// Frame header parser and payload unmasker: one byte in, one result out.
// Depends on wsd_pkg.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    output res_t        res
);

    phase_t      phase_reg, phase_next;
    logic        final_reg, final_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] payload_left_reg, payload_left_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_pos_reg, mask_pos_next;
    logic [1:0]  open_type_reg, open_type_next;
    logic [31:0] msg_bytes_reg, msg_bytes_next;
    logic [31:0] max_payload_reg;

    logic        data_start;
    logic        data_frame;
    logic [1:0]  frame_type;
    logic [6:0]  len7;
    logic        len_is_ext;
    logic        len_done;
    logic [63:0] len_val;
    logic        len_masked;
    logic        len_bad;
    logic [32:0] msg_sum;
    logic        sum_bad;
    logic        hdr_bad;
    logic        frame_last_byte;
    logic        msg_last;
    logic [7:0]  key_byte;

    assign data_start = (opcode_reg == OP_TEXT) || (opcode_reg == OP_BINARY);
    assign data_frame = data_start || (opcode_reg == OP_CONT);
    assign frame_type = data_start ? opcode_reg[1:0] : open_type_reg;
    assign msg_last   = data_frame && final_reg;

    assign len7       = data_byte[6:0];
    assign len_is_ext = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    assign len_done   = ((phase_reg == PH_HDR1) && !len_is_ext)
                     || ((phase_reg == PH_EXTLEN) && (len_left_reg == 4'd1));
    assign len_val    = (phase_reg == PH_HDR1) ? {57'd0, len7}
                                               : {payload_left_reg[55:0], data_byte};
    assign len_masked = (phase_reg == PH_HDR1) ? data_byte[7] : masked_reg;
    assign len_bad    = !len_masked || (|len_val[63:32])
                     || (len_val[31:0] > max_payload_reg);

    // A passed length check leaves the payload length below 2^32.
    assign msg_sum = {1'b0, msg_bytes_reg} + {1'b0, payload_left_reg[31:0]};
    assign sum_bad = (|payload_left_reg[63:32]) || (msg_sum > {1'b0, max_payload_reg});
    assign hdr_bad = ((opcode_reg == OP_CONT) && ((open_type_reg == MT_NONE) || sum_bad))
                  || (data_start && (open_type_reg != MT_NONE));

    assign frame_last_byte = (payload_left_reg == 64'd1);

    always_comb
    begin
        unique case (mask_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        final_next        = final_reg;
        opcode_next       = opcode_reg;
        masked_next       = masked_reg;
        len_left_next     = len_left_reg;
        payload_left_next = payload_left_reg;
        mask_key_next     = mask_key_reg;
        mask_pos_next     = mask_pos_reg;
        open_type_next    = open_type_reg;
        msg_bytes_next    = msg_bytes_reg;
        unique case (phase_reg)
            PH_HDR0:
            begin
                final_next  = data_byte[7];
                opcode_next = data_byte[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1, PH_EXTLEN:
            begin
                if (phase_reg == PH_HDR1)
                begin
                    masked_next = data_byte[7];
                    if (len_is_ext)
                    begin
                        len_left_next     = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        payload_left_next = 64'd0;
                        phase_next        = PH_EXTLEN;
                    end
                    else
                    begin
                        payload_left_next = len_val;
                    end
                end
                else
                begin
                    payload_left_next = len_val;
                    len_left_next     = len_left_reg - 4'd1;
                end
                if (len_done)
                begin
                    if (len_bad)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        mask_pos_next = 2'd0;
                        phase_next    = PH_MASK;
                    end
                end
            end
            PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], data_byte};
                mask_pos_next = mask_pos_reg + 2'd1;
                if (mask_pos_reg == 2'd3)
                begin
                    mask_pos_next = 2'd0;
                    if (opcode_reg == OP_CLOSE)
                    begin
                        phase_next = PH_CLOSED;
                    end
                    else if (hdr_bad)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        if (opcode_reg == OP_CONT)
                        begin
                            msg_bytes_next = msg_sum[31:0];
                        end
                        else if (data_start && !final_reg)
                        begin
                            open_type_next = opcode_reg[1:0];
                            msg_bytes_next = payload_left_reg[31:0];
                        end
                        if (payload_left_reg == 64'd0)
                        begin
                            phase_next = PH_HDR0;
                            if (msg_last)
                            begin
                                open_type_next = MT_NONE;
                                msg_bytes_next = 32'd0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                mask_pos_next     = mask_pos_reg + 2'd1;
                payload_left_next = payload_left_reg - 64'd1;
                if (frame_last_byte)
                begin
                    phase_next = PH_HDR0;
                    if (msg_last)
                    begin
                        open_type_next = MT_NONE;
                        msg_bytes_next = 32'd0;
                    end
                end
            end
            default:
            begin
                // closed or locked: hold
            end
        endcase
    end

    // Result for the byte being taken
    always_comb
    begin
        res.event_res    = EV_NONE;
        res.out_byte     = 8'd0;
        res.frame_end    = 1'b0;
        res.message_end  = 1'b0;
        res.message_type = open_type_reg;
        unique case (phase_reg)
            PH_HDR1, PH_EXTLEN:
            begin
                if (len_done && len_bad)
                begin
                    res.event_res = EV_ERROR;
                end
            end
            PH_MASK:
            begin
                if (mask_pos_reg == 2'd3)
                begin
                    if (opcode_reg == OP_CLOSE)
                    begin
                        res.event_res = EV_CLOSE;
                        res.frame_end = 1'b1;
                    end
                    else if (hdr_bad)
                    begin
                        res.event_res = EV_ERROR;
                    end
                    else
                    begin
                        res.message_type = frame_type;
                        if (payload_left_reg == 64'd0)
                        begin
                            res.frame_end   = 1'b1;
                            res.message_end = msg_last;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res.out_byte     = data_byte ^ key_byte;
                res.message_type = frame_type;
                if (data_frame)
                begin
                    res.event_res = EV_MSG;
                end
                else if (opcode_reg == OP_PING)
                begin
                    res.event_res = EV_PING;
                end
                else
                begin
                    res.event_res = EV_DISCARD;
                end
                if (frame_last_byte)
                begin
                    res.frame_end   = 1'b1;
                    res.message_end = msg_last;
                end
            end
            default:
            begin
                // header start, closed, locked: no event
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR0;
            final_reg        <= 1'b0;
            opcode_reg       <= OP_CONT;
            masked_reg       <= 1'b0;
            len_left_reg     <= 4'd0;
            payload_left_reg <= 64'd0;
            mask_key_reg     <= 32'd0;
            mask_pos_reg     <= 2'd0;
            open_type_reg    <= MT_NONE;
            msg_bytes_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            final_reg        <= final_next;
            opcode_reg       <= opcode_next;
            masked_reg       <= masked_next;
            len_left_reg     <= len_left_next;
            payload_left_reg <= payload_left_next;
            mask_key_reg     <= mask_key_next;
            mask_pos_reg     <= mask_pos_next;
            open_type_reg    <= open_type_next;
            msg_bytes_reg    <= msg_bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            max_payload_reg <= cfg_data;
        end
    end

endmodule

// ----- design/wsd_skid.sv -----
// Two-entry output buffer: result register plus skid register.
// Depends on wsd_pkg for the result type.
module wsd_skid
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic main_free;
    logic take;

    assign in_ready  = !skid_valid_reg;
    assign take      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            // skid is empty whenever a transfer is taken with main free
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else
            begin
                main_reg <= in_res;
            end
        end
        else if (take)
        begin
            skid_reg <= in_res;
        end
    end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// WebSocket client-to-server deframer, one byte per cycle while s_tready is high, one result per byte.
// Depends on wsd_pkg, wsd_parser and wsd_skid.
//
// Each byte taken on the slave side yields exactly one result on the master
// side, in the cycle after the transfer at the earliest. The block takes one
// byte every cycle while s_tready is high: header parsing, length checks and
// unmasking are done in one pass of logic from the frame state registers into
// a two-entry output buffer, and s_tready falls only when both entries hold
// results not yet taken. There is no start-up sweep; the block takes bytes
// from the first cycle after reset. After a close frame or a protocol error
// every result reports no event until reset. max_payload_bytes is written
// through cfg_* and must only change while no result is outstanding.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // frame_end
    output logic [5:0]  m_tuser,   // [2:0] event_res, [3] message_end, [5:4] message_type
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // max_payload_bytes
);

    res_t step_res;
    res_t out_res;
    logic step;

    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res       (step_res)
    );

    wsd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (step_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tlast = out_res.frame_end;
    assign m_tuser = {out_res.message_type, out_res.message_end, out_res.event_res};

endmodule

// ----- design/wsd_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer_defines.svh.
`include "websocket_frame_deframer_defines.svh"

module wsd_checker
    import wsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [5:0]  m_tuser
);

    logic [2:0] ev;
    logic       no_byte_ev;
    logic       stop_ev;

    assign ev         = m_tuser[2:0];
    assign no_byte_ev = (ev == EV_NONE) || (ev == EV_CLOSE) || (ev == EV_ERROR);
    assign stop_ev    = (ev == EV_CLOSE) || (ev == EV_ERROR);

    `WSD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")

    `WSD_ASSERT_NOW(a_byte_zero, clk, rst_n, m_tvalid && no_byte_ev, m_tdata == 8'd0,
        "byte set on a non-payload event")

    `WSD_ASSERT_NOW(a_msg_in_frame, clk, rst_n, m_tvalid && m_tuser[3], m_tlast,
        "message end without frame end")

    `WSD_ASSERT_NEXT(a_quiet_after_stop, clk, rst_n, m_tvalid && m_tready && stop_ev,
        !m_tvalid || (ev == EV_NONE),
        "event after close or error")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
